@@ rtl/core/nwo_pkg.sv @@
// Shared types and constants for the non-uniform wavetable oscillator.
// Used by the divider, the top level and the checker; depends on nothing.
package nwo_pkg;

  localparam int POS_W = 24;
  localparam int LVL_W = 16;
  localparam int DIV_W = 25;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_SAMPLE = 2'd2;

  localparam logic CFG_PHASE_STEP = 1'b0;
  localparam logic CFG_PERIOD     = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [LVL_W-1:0] level;
  } pt_t;

  // Request to the shared divider: the remainder starts at rem_init and the
  // dividend bits of dq_init are shifted in, most significant first.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] rem_init;
    logic [DIV_W-1:0] dq_init;
    logic [DIV_W-1:0] divisor;
    logic [4:0]       steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/core/nonuniform_wavetable_oscillator_unit.sv @@
// Top level of the non-uniform wavetable oscillator: sequencer, tables, arithmetic.
// Depends on nwo_pkg and instantiates the shared divider nwo_div.
//
// Channel | Direction | Handshake          | Payload
// in_     | input     | tvalid/tready      | tuser: req_type; tdata: index, pos, level, gain
// out_    | output    | tvalid/tready      | tdata: sample, segment_index
// cfg_    | input     | cfg_we, no wait    | cfg_addr selects phase_step or period
//
// A load item writes the pending table and leaves the input ready. A start item
// copies the pending table into the active table. A sample item finds its segment
// by a linear search that reads one table point per cycle; the fraction then
// uses the divider when it is not a plain 0 or one, and the phase advance uses
// the divider as well; a wrap of the segment adds a further table copy.
// Reset is synchronous and clears the sequencer, the phase and the output item;
// the tables hold nothing meaningful until written. The output register lets a
// finished item wait while the next input item is taken; a sample item stalls
// only when it needs the output register while that is still full.
module nonuniform_wavetable_oscillator_unit import nwo_pkg::*; #(
  parameter int POINTS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  input  logic [63:0] in_tdata,   // [6:0] entry_index, [30:7] entry_pos,
                                  // [46:31] entry_level, [62:47] gain, [63] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] sample, [22:16] segment_index, [23] zero
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [23:0] cfg_wdata
);

  localparam int AW = $clog2(POINTS);
  localparam logic [AW-1:0] LAST_SEG = AW'(POINTS - 2);

  typedef enum logic [3:0] {
    ST_IDLE, ST_COPY, ST_SRCH, ST_F0, ST_F1, ST_F2, ST_FRAC, ST_DIVW,
    ST_MUL1, ST_MUL2, ST_RND, ST_PADV, ST_PWAIT
  } state_t;

  state_t state_r;

  // Tables: one read port each, registered read data.
  pt_t act_mem [POINTS];
  pt_t pend_mem [POINTS];
  pt_t act_q, pend_q;
  logic [AW-1:0] act_ra, pend_ra;

  // Input fields.
  logic [6:0]       in_idx;
  logic [POS_W-1:0] in_pos;
  logic [LVL_W-1:0] in_lvl;
  logic [LVL_W-1:0] in_gain;
  assign in_idx  = in_tdata[6:0];
  assign in_pos  = in_tdata[30:7];
  assign in_lvl  = in_tdata[46:31];
  assign in_gain = in_tdata[62:47];

  logic [POS_W-1:0] step_r, period_r, phase_r;
  logic [AW-1:0]    j_r, seg_r, last_seg_r;
  logic [AW:0]      cp_r;
  logic             copy_smp_r;
  logic [LVL_W-1:0] gain_r;
  logic signed [LVL_W-1:0] lo_r, hi_r;
  logic [POS_W-1:0] plo_r;
  logic [POS_W:0]   phi_r;
  logic [16:0]      f_r;
  logic signed [34:0] prod_r;
  logic signed [50:0] total_r;
  logic             out_valid_r;
  logic [LVL_W-1:0] out_smp_r;
  logic [6:0]       out_seg_r;

  logic             in_acc;
  logic [POS_W-1:0] per;
  logic             hit;
  logic [AW-1:0]    seg_fin;
  logic signed [25:0] span_s, num_s;
  logic signed [33:0] v_s;
  logic signed [50:0] biased;
  logic signed [19:0] s_full;
  logic [LVL_W-1:0] s_sat;
  logic [POS_W:0]   sum_ph;

  div_req_t         div_req;
  div_stat_t        div_stat;
  logic [DIV_W-1:0] div_quot, div_rem;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  // A zero period behaves as a period of one.
  assign per       = (period_r == '0) ? POS_W'(1) : period_r;

  // Search: the last point at or below the phase, stopping at the first above.
  assign hit     = act_q.pos <= phase_r;
  assign seg_fin = hit ? j_r : seg_r;

  assign span_s = $signed({1'b0, phi_r}) - $signed({2'b00, plo_r});
  assign num_s  = $signed({2'b00, phase_r}) - $signed({2'b00, plo_r});

  // v = lo*65536 + (hi - lo)*f, which equals lo*(65536-f) + hi*f.
  assign v_s    = 34'(prod_r) + (34'(lo_r) <<< 16);
  // Round half up by adding 2^30 ahead of the arithmetic shift.
  assign biased = total_r + 51'sd1073741824;
  assign s_full = 20'(biased >>> 31);
  assign s_sat  = (s_full > 20'sd32767)  ? 16'h7FFF :
                  (s_full < -20'sd32768) ? 16'h8000 : s_full[15:0];

  assign sum_ph = {1'b0, phase_r} + {1'b0, step_r};

  always_comb begin
    act_ra = j_r + AW'(1);
    case (state_r)
      ST_IDLE: act_ra = '0;
      ST_F0:   act_ra = seg_r;
      ST_F1:   act_ra = (seg_r == LAST_SEG) ? AW'(0) : seg_r + AW'(1);
      default: act_ra = j_r + AW'(1);
    endcase
  end

  assign pend_ra = cp_r[AW-1:0];

  always_comb begin
    div_req          = '0;
    div_req.dq_init  = '0;
    div_req.rem_init = num_s[DIV_W-1:0];
    div_req.divisor  = span_s[DIV_W-1:0];
    div_req.steps    = 5'd16;
    case (state_r)
      ST_FRAC: div_req.start = !(span_s <= 0 || num_s <= 0 || num_s >= span_s);
      ST_PADV: begin
        div_req.start    = 1'b1;
        div_req.rem_init = '0;
        div_req.dq_init  = sum_ph;
        div_req.divisor  = {1'b0, per};
        div_req.steps    = 5'd25;
      end
      default: div_req.start = 1'b0;
    endcase
  end

  nwo_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .stat (div_stat),
    .quot (div_quot),
    .rem  (div_rem)
  );

  // Pending table: written by load items, read by the copy sweep.
  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == REQ_LOAD && {25'd0, in_idx} < 32'(POINTS)) begin
      pend_mem[AW'(in_idx)] <= '{pos: in_pos, level: in_lvl};
    end
    pend_q <= pend_mem[pend_ra];
  end

  // Active table: written only by the copy sweep, one entry behind its read.
  always_ff @(posedge clk) begin
    if (state_r == ST_COPY && cp_r != '0) begin
      act_mem[AW'(cp_r - (AW+1)'(1))] <= pend_q;
    end
    act_q <= act_mem[act_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      period_r    <= '1;
      phase_r     <= '0;
      last_seg_r  <= '0;
      out_valid_r <= 1'b0;
      copy_smp_r  <= 1'b0;
      cp_r        <= '0;
      j_r         <= '0;
      seg_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_PHASE_STEP: step_r   <= cfg_wdata;
          CFG_PERIOD:     period_r <= cfg_wdata;
          default:        ;
        endcase
      end
      // In the rounding state the output register is reloaded instead.
      if (out_valid_r && out_tready && state_r != ST_RND) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_tuser)
              REQ_START: begin
                cp_r       <= '0;
                copy_smp_r <= 1'b0;
                state_r    <= ST_COPY;
              end
              REQ_SAMPLE: begin
                gain_r  <= in_gain;
                j_r     <= '0;
                seg_r   <= '0;
                state_r <= ST_SRCH;
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_COPY: begin
          cp_r <= cp_r + (AW+1)'(1);
          if (cp_r == (AW+1)'(POINTS)) begin
            if (copy_smp_r) begin
              state_r <= ST_F0;
            end else begin
              phase_r    <= '0;
              last_seg_r <= '0;
              state_r    <= ST_IDLE;
            end
          end
        end
        ST_SRCH: begin
          seg_r <= seg_fin;
          if (hit && j_r != LAST_SEG) begin
            j_r <= j_r + AW'(1);
          end else begin
            last_seg_r <= seg_fin;
            if (seg_fin < last_seg_r) begin
              // The phase wrapped: take the pending table before interpolating.
              cp_r       <= '0;
              copy_smp_r <= 1'b1;
              state_r    <= ST_COPY;
            end else begin
              state_r <= ST_F0;
            end
          end
        end
        ST_F0: state_r <= ST_F1;
        ST_F1: begin
          plo_r   <= act_q.pos;
          lo_r    <= $signed(act_q.level);
          state_r <= ST_F2;
        end
        ST_F2: begin
          hi_r    <= $signed(act_q.level);
          phi_r   <= (seg_r == LAST_SEG) ? {1'b0, act_q.pos} + {1'b0, per}
                                         : {1'b0, act_q.pos};
          state_r <= ST_FRAC;
        end
        ST_FRAC: begin
          if (span_s <= 0 || num_s <= 0) begin
            f_r     <= '0;
            state_r <= ST_MUL1;
          end else if (num_s >= span_s) begin
            f_r     <= 17'h10000;
            state_r <= ST_MUL1;
          end else begin
            state_r <= ST_DIVW;
          end
        end
        ST_DIVW: begin
          if (div_stat.done) begin
            f_r     <= {1'b0, div_quot[15:0]};
            state_r <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          prod_r  <= (18'(hi_r) - 18'(lo_r)) * $signed({1'b0, f_r});
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          total_r <= v_s * $signed({1'b0, gain_r});
          state_r <= ST_RND;
        end
        ST_RND: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_smp_r   <= s_sat;
            out_seg_r   <= 7'(seg_r);
            state_r     <= ST_PADV;
          end
        end
        ST_PADV: state_r <= ST_PWAIT;
        ST_PWAIT: begin
          if (div_stat.done) begin
            phase_r <= div_rem[POS_W-1:0];
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_seg_r, out_smp_r};

endmodule

@@ rtl/core/nwo_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nwo_pkg for the request and status structs.
module nwo_div import nwo_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output div_stat_t        stat,
  output logic [DIV_W-1:0] quot,
  output logic [DIV_W-1:0] rem
);

  logic [DIV_W-1:0] rem_r, dq_r, div_r;
  logic [4:0]       cnt_r;
  logic             busy_r, done_r;
  logic [DIV_W:0]   trial;
  logic             ge;

  // The remainder always stays below the divisor, so it fits in DIV_W bits.
  assign trial = {rem_r, dq_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
        rem_r  <= req.rem_init;
        dq_r   <= req.dq_init;
        div_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= ge ? DIV_W'(trial - {1'b0, div_r}) : trial[DIV_W-1:0];
        dq_r  <= {dq_r[DIV_W-2:0], ge};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = dq_r;
  assign rem       = rem_r;

endmodule

@@ rtl/core/nwo_chk.sv @@
// Port-level checker for the oscillator top level, attached by bind.
// Depends on nwo_pkg for the request codes.
module nwo_chk import nwo_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output item changed while stalled");

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_SAMPLE |=> !in_tready)
    else $error("ready while a sample item is in work");

  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_LOAD |=> in_tready)
    else $error("load item held the input");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output item present after reset");

endmodule

bind nonuniform_wavetable_oscillator_unit nwo_chk u_nwo_chk (.*);
